@@ rtl/core/cnob_pkg.sv @@
// ----------------------------------------------------------------------------
// cnob_pkg
// Types and constants for the forward cone nearest obstacle brake block.
// ----------------------------------------------------------------------------
`default_nettype none

package cnob_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONE,
    ST_CMP,
    ST_BRAKE,
    ST_FRAC,
    ST_LEVEL,
    ST_EMIT
  } state_t;

  // drive mode codes
  localparam logic [1:0] DRIVE_NEUTRAL = 2'd0;
  localparam logic [1:0] DRIVE_REVERSE = 2'd1;
  localparam logic [1:0] DRIVE_FORWARD = 2'd2;

  // register indexes
  localparam logic [1:0] REG_CONE_SLOPE   = 2'd0;
  localparam logic [1:0] REG_NEUTRAL_ZONE = 2'd1;
  localparam logic [1:0] REG_BRAKE_SLOPE  = 2'd2;
  localparam logic [1:0] REG_MAX_SPEED    = 2'd3;

  // register reset values
  localparam logic [15:0] CONE_SLOPE_RST   = 16'd256;
  localparam logic [15:0] NEUTRAL_ZONE_RST = 16'd16384;
  localparam logic [23:0] BRAKE_SLOPE_RST  = 24'd13300;
  localparam logic [15:0] MAX_SPEED_RST    = 16'd13107;

  // nearest distance meaning no obstacle
  localparam logic [13:0] NONE_MM = 14'd16383;

  // one in Q24 and the lowest brake fraction in Q1.15
  localparam logic signed [40:0] ONE_Q24  = 41'sd16777216;
  localparam logic signed [40:0] FRAC_MIN = -41'sd32768;

  // lowest brake fraction at output width
  localparam logic signed [16:0] FRAC_SAT = -17'sd32768;

endpackage

`default_nettype wire

@@ rtl/core/cone_nearest_obstacle_brake.sv @@
// ----------------------------------------------------------------------------
// cone_nearest_obstacle_brake
// Tracks the nearest scan point inside a forward cone and turns it into a
// drive decision (neutral, reverse or forward) at the end of each scan.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_*      | in        | s_tvalid/s_tready  | point_x, point_y, tlast
//  m_*      | out       | m_tvalid/m_tready  | mode, level, fraction, nearest
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and data
//
// A point that is not last passes through accept, cone multiply and compare.
// A last point goes on to the brake multiply and, when no point qualified,
// straight to emit; else to the fraction step and, for reverse, the level
// multiply before emit, which waits for the output register. One 24x16
// multiplier is shared by the cone test, brake fraction and reverse level.
// Reset clears the sequencer, the running minimum and the registers.
// A new point is taken while an earlier result still waits in the output.
`default_nettype none

module cone_nearest_obstacle_brake (
  input  wire logic        clk,
  input  wire logic        rst,
  // input points
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // point_x[14:0], point_y[29:15], zero fill
  input  wire logic        s_tlast,   // last_point
  // drive decisions
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [55:0] m_tdata,   // drive_mode[1:0], drive_level[17:2],
                                      // brake_fraction[34:18],
                                      // nearest_forward_mm[48:35], zero fill
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic  [1:0] cfg_index,
  input  wire logic [23:0] cfg_data
);

  cnob_pkg::state_t state, state_next;

  // configuration registers
  logic [15:0] cone_slope;
  logic [15:0] neutral_zone;
  logic [23:0] brake_slope;
  logic [15:0] max_speed;

  // item and working registers
  logic signed [14:0] y_q;
  logic        [14:0] ax_q;
  logic               last_q;
  logic        [13:0] nearest;
  logic        [39:0] prod;
  logic signed [16:0] frac_q;
  logic         [1:0] mode_q;

  // output register
  logic  [1:0] out_mode;
  logic [15:0] out_level;
  logic [16:0] out_frac;
  logic [13:0] out_near;

  // shared multiplier operands
  logic [23:0] mul_a;
  logic [15:0] mul_b;
  logic        prod_en;
  logic        out_free;

  // datapath helpers
  logic [14:0]        ax_in;
  logic               y_hit;
  logic signed [40:0] diff;
  logic signed [40:0] diff_sh;
  logic signed [16:0] frac_calc;
  logic  [1:0]        mode_calc;
  logic [15:0]        level_calc;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {7'd0, out_near, out_frac, out_level, out_mode};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cone_slope   <= cnob_pkg::CONE_SLOPE_RST;
      neutral_zone <= cnob_pkg::NEUTRAL_ZONE_RST;
      brake_slope  <= cnob_pkg::BRAKE_SLOPE_RST;
      max_speed    <= cnob_pkg::MAX_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cnob_pkg::REG_CONE_SLOPE:   cone_slope   <= cfg_data[15:0];
        cnob_pkg::REG_NEUTRAL_ZONE: neutral_zone <= cfg_data[15:0];
        cnob_pkg::REG_BRAKE_SLOPE:  brake_slope  <= cfg_data;
        cnob_pkg::REG_MAX_SPEED:    max_speed    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // absolute value of the sideways coordinate
  assign ax_in = s_tdata[14] ? (~s_tdata[14:0] + 15'd1) : s_tdata[14:0];

  // point qualifies: forward of 1 mm, inside the cone, nearer than the minimum
  assign y_hit = !y_q[14] && (y_q[13:0] > 14'd1)
              && ({18'd0, y_q[13:0], 8'd0} > {1'b0, prod[38:0]})
              && (y_q[13:0] < nearest);

  // brake fraction from the distance product, floor shift and low saturation
  always_comb begin
    diff    = cnob_pkg::ONE_Q24 - $signed({1'b0, prod});
    diff_sh = diff >>> 9;
    if (diff_sh < cnob_pkg::FRAC_MIN) begin
      frac_calc = cnob_pkg::FRAC_SAT;
    end else begin
      frac_calc = diff_sh[16:0];
    end
    if (!frac_calc[16] && (frac_calc != 17'sd0)) begin
      if (frac_calc[15:0] < neutral_zone) begin
        mode_calc = cnob_pkg::DRIVE_NEUTRAL;
      end else begin
        mode_calc = cnob_pkg::DRIVE_REVERSE;
      end
    end else begin
      mode_calc = cnob_pkg::DRIVE_FORWARD;
    end
  end

  // drive level from the mode
  always_comb begin
    case (mode_q)
      cnob_pkg::DRIVE_REVERSE: level_calc = prod[30:15];
      cnob_pkg::DRIVE_FORWARD: level_calc = max_speed;
      default:                 level_calc = 16'd0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cnob_pkg::ST_IDLE:  if (s_tvalid) state_next = cnob_pkg::ST_CONE;
      cnob_pkg::ST_CONE:  state_next = cnob_pkg::ST_CMP;
      cnob_pkg::ST_CMP:   state_next = last_q ? cnob_pkg::ST_BRAKE : cnob_pkg::ST_IDLE;
      cnob_pkg::ST_BRAKE: begin
        state_next = (nearest == cnob_pkg::NONE_MM) ? cnob_pkg::ST_EMIT
                                                    : cnob_pkg::ST_FRAC;
      end
      cnob_pkg::ST_FRAC: begin
        state_next = (mode_calc == cnob_pkg::DRIVE_REVERSE) ? cnob_pkg::ST_LEVEL
                                                            : cnob_pkg::ST_EMIT;
      end
      cnob_pkg::ST_LEVEL: state_next = cnob_pkg::ST_EMIT;
      cnob_pkg::ST_EMIT:  if (out_free) state_next = cnob_pkg::ST_IDLE;
      default:            state_next = cnob_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    s_tready = 1'b0;
    prod_en  = 1'b0;
    mul_a    = {8'd0, cone_slope};
    mul_b    = {1'b0, ax_q};
    case (state)
      cnob_pkg::ST_IDLE:  s_tready = 1'b1;
      cnob_pkg::ST_CONE:  prod_en  = 1'b1;
      cnob_pkg::ST_BRAKE: begin
        prod_en = 1'b1;
        mul_a   = brake_slope;
        mul_b   = {2'd0, nearest};
      end
      cnob_pkg::ST_LEVEL: begin
        prod_en = 1'b1;
        mul_a   = {8'd0, max_speed};
        mul_b   = frac_q[15:0];
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnob_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      y_q    <= s_tdata[29:15];
      ax_q   <= ax_in;
      last_q <= s_tlast;
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= 40'(mul_a) * 40'(mul_b);
    end
  end

  // brake fraction and mode
  always_ff @(posedge clk) begin
    if (state == cnob_pkg::ST_BRAKE) begin
      frac_q <= cnob_pkg::FRAC_SAT;
      mode_q <= cnob_pkg::DRIVE_FORWARD;
    end else if (state == cnob_pkg::ST_FRAC) begin
      frac_q <= frac_calc;
      mode_q <= mode_calc;
    end
  end

  // running minimum, cleared once the decision word is loaded into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      nearest <= cnob_pkg::NONE_MM;
    end else if (state == cnob_pkg::ST_CMP && y_hit) begin
      nearest <= y_q[13:0];
    end else if (state == cnob_pkg::ST_EMIT && out_free) begin
      nearest <= cnob_pkg::NONE_MM;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == cnob_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cnob_pkg::ST_EMIT && out_free) begin
      out_mode  <= mode_q;
      out_level <= level_calc;
      out_frac  <= frac_q;
      out_near  <= nearest;
    end
  end

  // minimum only falls, except when it is cleared after a decision
  a_min_monotonic: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != cnob_pkg::ST_EMIT) |-> (nearest <= $past(nearest)))
    else $error("running minimum grew outside a decision");

  // the minimum is back at no obstacle after a decision word is loaded
  a_min_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == cnob_pkg::ST_EMIT && out_free) |=> (nearest == cnob_pkg::NONE_MM))
    else $error("running minimum not cleared after decision");

  // neutral gives no throttle
  a_neutral_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_mode == cnob_pkg::DRIVE_NEUTRAL) |-> (out_level == 16'd0))
    else $error("neutral decision with nonzero level");

  // forward runs at full throttle
  a_forward_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_mode == cnob_pkg::DRIVE_FORWARD) |-> (out_level == max_speed))
    else $error("forward decision not at max speed");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the forward cone nearest obstacle brake block.
// A directed table covers the cone edge, ignored points, the range limit,
// the empty scan and the fraction extremes. Random scans then run under
// several register settings. Every drive word is checked against a table
// value or an in-bench predictor while the point stream idles in bursts
// and the drive stream stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_top;

  // one drive decision, as carried on m_tdata
  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        level;
    logic signed [16:0] frac;
    logic [13:0]        nearest;
  } drive_word_t;

  // one row of the directed table: a register write or a scan point
  typedef struct packed {
    bit                 is_reg;
    logic [1:0]         reg_idx;
    logic [23:0]        reg_val;
    logic signed [14:0] x;
    logic signed [14:0] y;
    bit                 last;
    bit                 fixed_want;
    drive_word_t        want;
  } scan_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;   // point_x[14:0], point_y[29:15], zero fill
  logic        s_tlast   = 1'b0; // last_point
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;          // drive_mode[1:0], drive_level[17:2],
                                 // brake_fraction[34:18],
                                 // nearest_forward_mm[48:35], zero fill
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;

  cone_nearest_obstacle_brake DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the running minimum
  logic [15:0] cone_slope   = cnob_pkg::CONE_SLOPE_RST;
  logic [15:0] neutral_zone = cnob_pkg::NEUTRAL_ZONE_RST;
  logic [23:0] brake_slope  = cnob_pkg::BRAKE_SLOPE_RST;
  logic [15:0] max_speed    = cnob_pkg::MAX_SPEED_RST;
  logic [13:0] nearest_mm   = cnob_pkg::NONE_MM;

  drive_word_t pending_drive[$];
  scan_row_t   dir_rows[$];
  int          fail_count = 0;
  int          burst_left = 0;
  logic [9:0]  rx_cycle   = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("FAIL cone_nearest_obstacle_brake");
    $finish;
  end

  // fold one point into the minimum; on a last point work out the decision
  task automatic predict_drive(input logic signed [14:0] px, input logic signed [14:0] py,
                               input bit last, output bit emit, output drive_word_t w);
    longint ax;
    longint d;
    longint f;
    emit = 1'b0;
    w    = '0;
    if (py > 15'sd1) begin
      ax = (px < 0) ? -longint'(px) : longint'(px);
      if (longint'(py) * 256 > longint'(cone_slope) * ax &&
          longint'(py) < longint'(nearest_mm))
        nearest_mm = py[13:0];
    end
    if (last) begin
      if (nearest_mm == cnob_pkg::NONE_MM) begin
        f       = -32768;
        w.mode  = cnob_pkg::DRIVE_FORWARD;
        w.level = max_speed;
      end else begin
        d = 64'sd16777216 - longint'(brake_slope) * longint'(nearest_mm);
        f = d >>> 9;
        if (f < -32768) f = -32768;
        if (f > 32768) f = 32768;
        if (f > 0 && f < longint'(neutral_zone)) begin
          w.mode  = cnob_pkg::DRIVE_NEUTRAL;
          w.level = '0;
        end else if (f > 0) begin
          w.mode  = cnob_pkg::DRIVE_REVERSE;
          w.level = 16'((f * longint'(max_speed)) >>> 15);
        end else begin
          w.mode  = cnob_pkg::DRIVE_FORWARD;
          w.level = max_speed;
        end
      end
      w.frac     = f[16:0];
      w.nearest  = nearest_mm;
      nearest_mm = cnob_pkg::NONE_MM;
      emit       = 1'b1;
    end
  endtask

  // hold the point stream until every drive word is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_drive.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    drain_results();
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cnob_pkg::REG_CONE_SLOPE:   cone_slope   = val[15:0];
      cnob_pkg::REG_NEUTRAL_ZONE: neutral_zone = val[15:0];
      cnob_pkg::REG_BRAKE_SLOPE:  brake_slope  = val;
      cnob_pkg::REG_MAX_SPEED:    max_speed    = val[15:0];
      default: ;
    endcase
  endtask

  // send one point in bursts with random gaps, then predict
  task automatic send_point(input logic signed [14:0] px, input logic signed [14:0] py,
                            input bit last, input bit fixed_want, input drive_word_t want);
    int          gap;
    bit          emit;
    drive_word_t w;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, py, px};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    predict_drive(px, py, last, emit, w);
    if (emit) pending_drive.push_back(fixed_want ? want : w);
  endtask

  // random register setting, extremes favored
  task automatic pick_config();
    logic [23:0] v;
    case ($urandom_range(0, 4))
      0: v = 24'd0;
      1: v = 24'd65535;
      2: v = 24'd256;
      default: v = 24'($urandom_range(0, 2048));
    endcase
    write_reg(cnob_pkg::REG_CONE_SLOPE, v);
    case ($urandom_range(0, 4))
      0: v = 24'd0;
      1: v = 24'd32768;
      2: v = 24'd65535;
      default: v = 24'($urandom_range(0, 32768));
    endcase
    write_reg(cnob_pkg::REG_NEUTRAL_ZONE, v);
    case ($urandom_range(0, 5))
      0: v = 24'd0;
      1: v = 24'hFFFFFF;
      2: v = 24'($urandom);
      default: v = 24'($urandom_range(1000, 200000));
    endcase
    write_reg(cnob_pkg::REG_BRAKE_SLOPE, v);
    case ($urandom_range(0, 4))
      0: v = 24'd0;
      1: v = 24'd65535;
      default: v = 24'($urandom_range(0, 65535));
    endcase
    write_reg(cnob_pkg::REG_MAX_SPEED, v);
  endtask

  // mostly points near the brake knee and the cone edge, some raw noise
  task automatic make_point(output logic signed [14:0] px, output logic signed [14:0] py);
    longint knee;
    longint reach;
    longint mag;
    if ($urandom_range(0, 6) == 0) begin
      px = 15'($urandom);
      py = 15'($urandom);
    end else begin
      knee = (brake_slope == 0) ? 16382 : 64'd16777216 / brake_slope;
      if (knee < 2) knee = 2;
      if (knee > 8191) knee = 8191;
      py    = 15'($urandom_range(2, int'(2 * knee)));
      reach = (cone_slope == 0) ? 16383 : (longint'(py) * 256) / cone_slope;
      mag   = $urandom_range(0, int'((reach > 16382) ? 16382 : reach + 1));
      px    = $urandom_range(0, 1) ? -15'(mag) : 15'(mag);
    end
  endtask

  task automatic add_pt(input logic signed [14:0] px, input logic signed [14:0] py,
                        input bit last);
    scan_row_t r;
    r      = '0;
    r.x    = px;
    r.y    = py;
    r.last = last;
    dir_rows.push_back(r);
  endtask

  task automatic add_fixed(input logic signed [14:0] px, input logic signed [14:0] py,
                           input logic [1:0] mode, input logic [15:0] level,
                           input logic signed [16:0] frac, input logic [13:0] nearest);
    scan_row_t r;
    r              = '0;
    r.x            = px;
    r.y            = py;
    r.last         = 1'b1;
    r.fixed_want   = 1'b1;
    r.want.mode    = mode;
    r.want.level   = level;
    r.want.frac    = frac;
    r.want.nearest = nearest;
    dir_rows.push_back(r);
  endtask

  task automatic add_reg(input logic [1:0] idx, input logic [23:0] val);
    scan_row_t r;
    r         = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endtask

  // compare one drive word with the oldest expectation
  task automatic take_word(input logic [55:0] raw);
    drive_word_t got;
    drive_word_t want;
    got.mode    = raw[1:0];
    got.level   = raw[17:2];
    got.frac    = raw[34:18];
    got.nearest = raw[48:35];
    if (pending_drive.size() == 0) begin
      $display("%0t unexpected drive word, expected none, actual %h", $time, raw);
      fail_count++;
    end else begin
      want = pending_drive.pop_front();
      if (got.mode !== want.mode) begin
        $display("%0t drive_mode expected %0d actual %0d", $time, want.mode, got.mode);
        fail_count++;
      end
      if (got.level !== want.level) begin
        $display("%0t drive_level expected %0d actual %0d", $time, want.level, got.level);
        fail_count++;
      end
      if (got.frac !== want.frac) begin
        $display("%0t brake_fraction expected %0d actual %0d", $time, want.frac, got.frac);
        fail_count++;
      end
      if (got.nearest !== want.nearest) begin
        $display("%0t nearest_forward_mm expected %0d actual %0d", $time, want.nearest,
                 got.nearest);
        fail_count++;
      end
    end
  endtask

  // drive side: check accepted words, stall on a rotating pattern
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) take_word(m_tdata);
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (rx_cycle[2:0] < 3'd3);
      default: m_tready <= (rx_cycle[4:0] == 5'd0);
    endcase
  end

  // stimulus
  initial begin
    logic signed [14:0] px;
    logic signed [14:0] py;
    int                 sent;
    int                 n;
    scan_row_t          r;

    // reset values, empty scans and ignored points
    add_fixed(15'sd0, 15'sd0, cnob_pkg::DRIVE_FORWARD, cnob_pkg::MAX_SPEED_RST,
              -17'sd32768, cnob_pkg::NONE_MM);
    add_pt(-15'sd16383, 15'sd16383, 1'b0);
    add_fixed(15'sd16383, 15'sd16383, cnob_pkg::DRIVE_FORWARD, cnob_pkg::MAX_SPEED_RST,
              -17'sd32768, cnob_pkg::NONE_MM);
    add_fixed(15'sd0, 15'sd1, cnob_pkg::DRIVE_FORWARD, cnob_pkg::MAX_SPEED_RST,
              -17'sd32768, cnob_pkg::NONE_MM);
    add_fixed(15'sd0, -15'sd16383, cnob_pkg::DRIVE_FORWARD, cnob_pkg::MAX_SPEED_RST,
              -17'sd32768, cnob_pkg::NONE_MM);
    // cone edge: outside, just inside, on the edge
    add_pt(15'sd16383, 15'sd2, 1'b0);
    add_pt(-15'sd1, 15'sd2, 1'b0);
    add_pt(15'sd0, 15'sd100, 1'b1);
    add_pt(15'sd5, 15'sd1000, 1'b0);
    add_pt(15'sd1000, 15'sd1000, 1'b1);
    add_pt(15'sd0, 15'sd2000, 1'b1);
    // widest and narrowest cone
    add_reg(cnob_pkg::REG_CONE_SLOPE, 24'd0);
    add_pt(-15'sd16383, 15'sd3, 1'b1);
    add_reg(cnob_pkg::REG_CONE_SLOPE, 24'd65535);
    add_pt(15'sd0, 15'sd16382, 1'b1);
    // fraction exactly zero, then saturated low
    add_reg(cnob_pkg::REG_BRAKE_SLOPE, 24'd65536);
    add_fixed(15'sd0, 15'sd256, cnob_pkg::DRIVE_FORWARD, cnob_pkg::MAX_SPEED_RST,
              17'sd0, 14'd256);
    add_reg(cnob_pkg::REG_BRAKE_SLOPE, 24'hFFFFFF);
    add_fixed(15'sd0, 15'sd16382, cnob_pkg::DRIVE_FORWARD, cnob_pkg::MAX_SPEED_RST,
              -17'sd32768, 14'd16382);
    // full fraction against the neutral threshold at one and above one
    add_reg(cnob_pkg::REG_BRAKE_SLOPE, 24'd0);
    add_reg(cnob_pkg::REG_NEUTRAL_ZONE, 24'd32768);
    add_reg(cnob_pkg::REG_MAX_SPEED, 24'd65535);
    add_fixed(15'sd0, 15'sd2, cnob_pkg::DRIVE_REVERSE, 16'd65535, 17'sd32768, 14'd2);
    add_reg(cnob_pkg::REG_NEUTRAL_ZONE, 24'd65535);
    add_fixed(15'sd0, 15'sd7, cnob_pkg::DRIVE_NEUTRAL, 16'd0, 17'sd32768, 14'd7);
    add_reg(cnob_pkg::REG_MAX_SPEED, 24'd0);
    add_reg(cnob_pkg::REG_NEUTRAL_ZONE, 24'd0);
    add_fixed(15'sd0, 15'sd9, cnob_pkg::DRIVE_REVERSE, 16'd0, 17'sd32768, 14'd9);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.is_reg)
        write_reg(r.reg_idx, r.reg_val);
      else
        send_point(r.x, r.y, r.last, r.fixed_want, r.want);
    end

    // random scans under several register settings
    for (int phase = 0; phase < 8; phase++) begin
      pick_config();
      sent = 0;
      while (sent < 150) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          make_point(px, py);
          send_point(px, py, k == n - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("PASS cone_nearest_obstacle_brake");
    else
      $display("FAIL cone_nearest_obstacle_brake");
    $finish;
  end

endmodule

@@ cone_nearest_obstacle_brake.f @@
rtl/core/cnob_pkg.sv
rtl/core/cone_nearest_obstacle_brake.sv
tb/tb_top.sv
